// ----- design/plvp_pkg.sv -----
// Package of shared types and constants for the point light vertex projector.
package plvp_pkg;

   localparam int unsigned CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LIGHT_X      = 3'd0,
      REG_LIGHT_Y      = 3'd1,
      REG_LIGHT_Z      = 3'd2,
      REG_LIGHT_RADIUS = 3'd3,
      REG_COLOR_RED    = 3'd4,
      REG_COLOR_GREEN  = 3'd5,
      REG_COLOR_BLUE   = 3'd6,
      REG_LIGHT_BACKS  = 3'd7
   } csr_index_type;

   localparam logic       OP_VERTEX   = 1'b0;
   localparam logic       OP_TRIANGLE = 1'b1;
   localparam logic [5:0] CODE_BACK   = 6'd63;
   localparam logic signed [19:0] TEX_MAX = 20'sd524287;
   localparam logic signed [19:0] TEX_MIN = -20'sd524288;
   localparam logic signed [35:0] TEX_HALF = 36'sd32768;

   localparam logic [1:0] DIV_SEL_S   = 2'd0;
   localparam logic [1:0] DIV_SEL_T   = 2'd1;
   localparam logic [1:0] DIV_SEL_MOD = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the input item and compute distances
      logic div_start;  // start one division
      logic [1:0] div_sel; // texcoord s, texcoord t or modulate
      logic tri_read;   // issue clip store reads for one corner
      logic [1:0] corner;
      logic finish;     // assemble the result into the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic is_tri;
      logic back;
      logic mod_div;    // modulate needs a division
   } ctrl_stat_type;

endpackage

// ----- design/plvp_divider.sv -----
// Restoring divider for unsigned operands, one quotient bit per cycle.
module plvp_divider #(
   parameter int unsigned NUM_W = 52,
   parameter int unsigned DEN_W = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;

   always_comb begin
      q_in   = q_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      diff   = {1'b0, trial} - {2'b00, den_ff};
      if (start) begin
         q_in   = numer;
         rem_in = '0;
         den_in = denom;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (!diff[DEN_W+1]) begin
            rem_in = diff[DEN_W:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign busy = (cnt_ff != '0);
   assign quot = q_ff;
endmodule

// ----- design/plvp_datapath.sv -----
// Datapath: registers, distance and facing test, divisions, clip store and result.
module plvp_datapath #(
   parameter int unsigned MAX_VERTS = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_data,
   input  logic [183:0]            req_tdata,
   input  logic                    req_tuser,
   input  plvp_pkg::ctrl_cmd_type  cmd,
   output plvp_pkg::ctrl_stat_type stat,
   output logic                    rsp_kind,
   output logic [80:0]             rsp_data
);
   localparam int unsigned AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;

   logic signed [31:0] lx_ff, ly_ff, lz_ff;
   logic [30:0]        rad_ff;
   logic [7:0]         cr_ff, cg_ff, cb_ff;
   logic               backs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lx_ff <= '0; ly_ff <= '0; lz_ff <= '0;
         rad_ff <= 31'd256;
         cr_ff <= 8'd255; cg_ff <= 8'd255; cb_ff <= 8'd255;
         backs_ff <= 1'b0;
      end else if (csr_valid) begin
         case (plvp_pkg::csr_index_type'(csr_index))
            plvp_pkg::REG_LIGHT_X:      lx_ff <= csr_data;
            plvp_pkg::REG_LIGHT_Y:      ly_ff <= csr_data;
            plvp_pkg::REG_LIGHT_Z:      lz_ff <= csr_data;
            plvp_pkg::REG_LIGHT_RADIUS: rad_ff <= csr_data[30:0];
            plvp_pkg::REG_COLOR_RED:    cr_ff <= csr_data[7:0];
            plvp_pkg::REG_COLOR_GREEN:  cg_ff <= csr_data[7:0];
            plvp_pkg::REG_COLOR_BLUE:   cb_ff <= csr_data[7:0];
            plvp_pkg::REG_LIGHT_BACKS:  backs_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Input item fields.
   logic [9:0]         f_vidx, f_ca, f_cb, f_cc;
   logic signed [31:0] f_px, f_py, f_pz;
   logic signed [15:0] f_nx, f_ny, f_nz;
   assign f_vidx = req_tdata[9:0];
   assign f_px   = req_tdata[41:10];
   assign f_py   = req_tdata[73:42];
   assign f_pz   = req_tdata[105:74];
   assign f_nx   = req_tdata[121:106];
   assign f_ny   = req_tdata[137:122];
   assign f_nz   = req_tdata[153:138];
   assign f_ca   = req_tdata[163:154];
   assign f_cb   = req_tdata[173:164];
   assign f_cc   = req_tdata[183:174];

   logic               tri_ff;
   logic [9:0]         vidx_ff;
   logic signed [33:0] dx_ff, dy_ff, dz_ff;
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic [30:0]        r_ff;
   logic [9:0]         crn_ff [3];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tri_ff  <= req_tuser;
         vidx_ff <= f_vidx;
         dx_ff   <= 34'(lx_ff) - 34'(f_px);
         dy_ff   <= 34'(ly_ff) - 34'(f_py);
         dz_ff   <= 34'(lz_ff) - 34'(f_pz);
         nx_ff   <= f_nx;
         ny_ff   <= f_ny;
         nz_ff   <= f_nz;
         r_ff    <= (rad_ff == '0) ? 31'd1 : rad_ff;
         crn_ff[0] <= f_ca;
         crn_ff[1] <= f_cb;
         crn_ff[2] <= f_cc;
      end
   end

   // Facing test: products registered, then summed.
   logic signed [49:0] px_ff, py_ff, pz_ff;
   logic signed [51:0] dot;
   logic               back;
   always_ff @(posedge clock) begin
      px_ff <= dx_ff * nx_ff;
      py_ff <= dy_ff * ny_ff;
      pz_ff <= dz_ff * nz_ff;
   end
   assign dot = 52'(px_ff) + 52'(py_ff) + 52'(pz_ff);
   assign back = !backs_ff && dot[51];

   // Clip bits.
   logic signed [35:0] r_s;
   logic signed [34:0] adz;
   logic [5:0] code;
   logic       mod_div;
   assign r_s = 36'(r_ff);
   assign adz = dz_ff[33] ? -35'(dz_ff) : 35'(dz_ff);
   always_comb begin
      code = '0;
      if (36'(dx_ff) * 2 < -r_s)      code[0] = 1'b1;
      else if (36'(dx_ff) * 2 > r_s)  code[1] = 1'b1;
      if (36'(dy_ff) * 2 < -r_s)      code[2] = 1'b1;
      else if (36'(dy_ff) * 2 > r_s)  code[3] = 1'b1;
      if (36'(dz_ff) > r_s)           code[4] = 1'b1;
      else if (36'(dz_ff) < -r_s)     code[5] = 1'b1;
   end
   assign mod_div = (code[5:4] == 2'b00) && !(36'(adz) * 2 < r_s);

   // Shared divider.
   logic [51:0] numer, quot;
   logic [33:0] mag;
   logic        div_busy;
   always_comb begin
      case (cmd.div_sel)
         plvp_pkg::DIV_SEL_S: mag = dx_ff[33] ? 34'(-dx_ff) : 34'(dx_ff);
         plvp_pkg::DIV_SEL_T: mag = dy_ff[33] ? 34'(-dy_ff) : 34'(dy_ff);
         default:             mag = 34'(r_s - 36'(adz));
      endcase
      numer = (cmd.div_sel == plvp_pkg::DIV_SEL_MOD) ? {1'b0, mag, 17'd0}
                                                      : {2'b00, mag, 16'd0};
   end
   plvp_divider #(.NUM_W(52), .DEN_W(31)) u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .numer(numer), .denom(r_ff), .busy(div_busy), .quot(quot));

   assign stat = '{div_busy: div_busy, is_tri: tri_ff, back: back, mod_div: mod_div};

   function automatic logic signed [19:0] sat_tex(input logic neg, input logic [51:0] q);
      logic signed [53:0] v;
      v = neg ? -54'(q) : 54'(q);
      v = v + 54'(plvp_pkg::TEX_HALF);
      if (v > 54'(plvp_pkg::TEX_MAX)) return plvp_pkg::TEX_MAX;
      if (v < 54'(plvp_pkg::TEX_MIN)) return plvp_pkg::TEX_MIN;
      return v[19:0];
   endfunction

   logic signed [19:0] s_ff, t_ff;
   logic [16:0]        mod_ff;
   logic [1:0]         sel_ff;
   logic               busy_q_ff;
   always_ff @(posedge clock) begin
      busy_q_ff <= div_busy;
      if (cmd.div_start) sel_ff <= cmd.div_sel;
      if (busy_q_ff && !div_busy) begin
         case (sel_ff)
            plvp_pkg::DIV_SEL_S: s_ff <= sat_tex(dx_ff[33], quot);
            plvp_pkg::DIV_SEL_T: t_ff <= sat_tex(dy_ff[33], quot);
            default:             mod_ff <= quot[16:0];
         endcase
      end
   end

   // Clip store.
   logic [5:0]    store [MAX_VERTS];
   logic [5:0]    rd_ff, and_ff;
   logic          rd_ok_ff;
   logic [9:0]    rd_idx;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [5:0]    fin_code;
   logic [16:0]   fin_mod;
   assign rd_idx  = crn_ff[cmd.corner];
   assign rd_addr = AW'(rd_idx);
   assign wr_addr = AW'(vidx_ff);
   always_comb begin
      fin_code = code;
      fin_mod  = '0;
      if (back) fin_code = plvp_pkg::CODE_BACK;
      else if (code[5:4] == 2'b00) fin_mod = mod_div ? mod_ff : 17'd65536;
   end
   always_ff @(posedge clock) begin
      if (cmd.finish && !tri_ff && 32'(vidx_ff) < MAX_VERTS)
         store[wr_addr] <= fin_code;
      if (cmd.tri_read) rd_ff <= store[rd_addr];
      rd_ok_ff <= cmd.tri_read && (32'(rd_idx) < MAX_VERTS);
   end
   logic [5:0] rd_val;
   assign rd_val = rd_ok_ff ? rd_ff : 6'd0;
   logic rd_v_ff;
   always_ff @(posedge clock) begin
      rd_v_ff <= cmd.tri_read;
      if (cmd.load) and_ff <= '1;
      else if (rd_v_ff) and_ff <= and_ff & rd_val;
   end

   logic [24:0] pr, pg, pb;
   assign pr = 25'(cr_ff) * 25'(fin_mod);
   assign pg = 25'(cg_ff) * 25'(fin_mod);
   assign pb = 25'(cb_ff) * 25'(fin_mod);

   logic [80:0] rsp_ff;
   logic        kind_ff;
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         kind_ff <= tri_ff;
         if (tri_ff) begin
            rsp_ff <= {1'(and_ff == 6'd0), and_ff, 24'd0, 40'd0, 10'd0};
         end else begin
            rsp_ff <= {1'b0, fin_code, pb[23:16], pg[23:16], pr[23:16],
                       back ? 20'd0 : t_ff, back ? 20'd0 : s_ff, vidx_ff};
         end
      end
   end
   assign rsp_data = rsp_ff;
   assign rsp_kind = kind_ff;
endmodule

// ----- design/plvp_controller.sv -----
// Controller state machine sequencing one item through the datapath.
module plvp_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  plvp_pkg::ctrl_stat_type stat,
   output plvp_pkg::ctrl_cmd_type  cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_DOT, S_DIV, S_WAIT, S_WAIT2, S_RD, S_RD_WAIT, S_FIN, S_OUT
   } state_type;

   state_type state_ff;
   logic [1:0] sel_ff, crn_ff;
   logic rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.load = (state_ff == S_IDLE) && req_tvalid;
      cmd.div_start = (state_ff == S_DIV);
      cmd.div_sel = sel_ff;
      cmd.tri_read = (state_ff == S_RD);
      cmd.corner = crn_ff;
      cmd.finish = (state_ff == S_FIN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff <= plvp_pkg::DIV_SEL_S;
         crn_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_tvalid) state_ff <= S_MUL;
            S_MUL: begin
               sel_ff <= plvp_pkg::DIV_SEL_S; crn_ff <= '0;
               state_ff <= stat.is_tri ? S_RD : S_DOT;
            end
            S_DOT: state_ff <= stat.back ? S_OUT : S_DIV;
            S_DIV: state_ff <= S_WAIT;
            S_WAIT: if (!stat.div_busy) state_ff <= S_WAIT2;
            S_WAIT2: begin
               if (sel_ff == plvp_pkg::DIV_SEL_S ||
                   (sel_ff == plvp_pkg::DIV_SEL_T && stat.mod_div)) begin
                  sel_ff <= sel_ff + 2'd1;
                  state_ff <= S_DIV;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_RD: begin
               crn_ff <= crn_ff + 2'd1;
               if (crn_ff == 2'd2) state_ff <= S_RD_WAIT;
            end
            S_RD_WAIT: state_ff <= S_OUT;
            S_OUT: if (!rsp_valid_ff || rsp_tready) state_ff <= S_FIN;
            S_FIN: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("accept while busy");
   a_fin_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN |-> !rsp_valid_ff || rsp_tready) else $error("overwrite");
endmodule

// ----- design/point_light_vertex_projector.sv -----
// Top level of the point light vertex projector.
// Input channel req_: one transaction is a vertex (tuser op 0) or triangle (op 1) item.
// Result channel rsp_: one result transaction per input transaction, in order.
// Configuration channel csr_: register index and data, to be written only while no item
// is in flight, which the block itself does not enforce; csr_ready is always high.
// A vertex that faces the light runs two divisions (texcoords s and t) before a valid
// result, and a third when the height falloff needs it. Each division runs on the one
// shared restoring divider, which forms a 52-bit quotient. A back-facing vertex skips
// the divisions, and a triangle instead does three reads of the clip store. One item
// is in work at a time; the next is accepted only after the result of the last is
// loaded into the output register.
// Reset clears the control state and loads the register reset values; the clip
// store holds nothing defined until written. When the receiver stalls, the result
// waits in the output register; the next item is still accepted and computed, then
// waits before the output until the register frees, and no further item is taken.
module point_light_vertex_projector #(
   parameter int unsigned MAX_VERTS = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vertex_index, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, corner_a,
   // corner_b, corner_c
   input  logic [183:0] req_tdata,
   input  logic         req_tuser, // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_index, tex_s, tex_t, lit_red, lit_green, lit_blue, clip_code, tri_lit, fill
   output logic [87:0]  rsp_tdata,
   output logic         rsp_tuser, // kind
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   plvp_pkg::ctrl_cmd_type  cmd;
   plvp_pkg::ctrl_stat_type stat;
   logic [80:0]  dp_rsp;
   logic         dp_kind;

   assign csr_ready = 1'b1;

   plvp_controller u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .stat(stat), .cmd(cmd));

   plvp_datapath #(.MAX_VERTS(MAX_VERTS)) u_dp (
      .clock(clock), .reset(reset), .csr_valid(csr_valid), .csr_index(csr_index),
      .csr_data(csr_data), .req_tdata(req_tdata), .req_tuser(req_tuser), .cmd(cmd),
      .stat(stat), .rsp_kind(dp_kind), .rsp_data(dp_rsp));

   assign rsp_tdata = {7'd0, dp_rsp};
   assign rsp_tuser = dp_kind;
endmodule
